### sv/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX    = 3'd2,
    MODE_SBS    = 3'd3,
    MODE_SU     = 3'd4,
    MODE_LHEX   = 3'd5
  } mode_t;

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_HT = 8'h09;

  localparam logic [15:0] HI_SUR_MIN = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // Up to four result bytes of one input byte, first byte in data[0].
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
    logic [1:0]      status;
  } grp_t;

  // Value of a hex digit in [3:0], bit 4 set when the byte is not one.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

  function automatic grp_t utf8_encode(input logic [20:0] cp);
    grp_t g;
    g = '0;
    g.status = ST_DATA;
    if (cp < 21'h80) begin
      g.cnt = 3'd1;
      g.data[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      g.cnt = 3'd2;
      g.data[0] = {3'b110, cp[10:6]};
      g.data[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      g.cnt = 3'd3;
      g.data[0] = {4'b1110, cp[15:12]};
      g.data[1] = {2'b10, cp[11:6]};
      g.data[2] = {2'b10, cp[5:0]};
    end else begin
      g.cnt = 3'd4;
      g.data[0] = {5'b11110, cp[20:18]};
      g.data[1] = {2'b10, cp[17:12]};
      g.data[2] = {2'b10, cp[11:6]};
      g.data[3] = {2'b10, cp[5:0]};
    end
    return g;
  endfunction

  function automatic grp_t end_grp(input logic [1:0] st);
    grp_t g;
    g = '0;
    g.cnt = 3'd1;
    g.status = st;
    return g;
  endfunction

endpackage

### sv/jsu_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_ifs
// Valid/ready stream interfaces for raw input bytes and decoded results.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

### sv/jsu_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decoder
// Escape state machine: turns one raw byte into a group of result bytes.
// ----------------------------------------------------------------------------
module jsu_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  output jsu_pkg::grp_t      grp
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     hex_cnt_r, hex_cnt_nxt;
  logic [11:0]    acc_r, acc_nxt;
  logic [9:0]     high_r, high_nxt;

  logic [4:0]     hv;
  logic [15:0]    cp16;
  logic [20:0]    cp_supp;
  logic           clr;

  assign hv      = jsu_pkg::hex_val(in_byte);
  assign cp16    = {acc_r, hv[3:0]};
  assign cp_supp = {1'b0, high_r, cp16[9:0]} + jsu_pkg::SUPP_BASE;

  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    acc_nxt     = acc_r;
    high_nxt    = high_r;
    grp         = '0;
    clr         = 1'b0;
    if (in_byte == jsu_pkg::CH_NUL) begin
      grp = jsu_pkg::end_grp(jsu_pkg::ST_ERR);
      clr = 1'b1;
    end else begin
      case (mode_r)
        jsu_pkg::MODE_ESC: begin
          mode_nxt    = jsu_pkg::MODE_NORMAL;
          grp.cnt     = 3'd1;
          grp.status  = jsu_pkg::ST_DATA;
          case (in_byte)
            jsu_pkg::CH_QUOTE: grp.data[0] = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BSL:   grp.data[0] = jsu_pkg::CH_BSL;
            jsu_pkg::CH_SLASH: grp.data[0] = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_B:     grp.data[0] = jsu_pkg::BYTE_BS;
            jsu_pkg::CH_F:     grp.data[0] = jsu_pkg::BYTE_FF;
            jsu_pkg::CH_N:     grp.data[0] = jsu_pkg::BYTE_LF;
            jsu_pkg::CH_R:     grp.data[0] = jsu_pkg::BYTE_CR;
            jsu_pkg::CH_T:     grp.data[0] = jsu_pkg::BYTE_HT;
            jsu_pkg::CH_U: begin
              grp         = '0;
              mode_nxt    = jsu_pkg::MODE_HEX;
              hex_cnt_nxt = 2'd0;
              acc_nxt     = '0;
            end
            default: begin
              grp = jsu_pkg::end_grp(jsu_pkg::ST_ERR);
              clr = 1'b1;
            end
          endcase
        end
        jsu_pkg::MODE_HEX, jsu_pkg::MODE_LHEX: begin
          if (hv[4]) begin
            grp = jsu_pkg::end_grp(jsu_pkg::ST_ERR);
            clr = 1'b1;
          end else if (hex_cnt_r != 2'd3) begin
            acc_nxt     = {acc_r[7:0], hv[3:0]};
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end else begin
            hex_cnt_nxt = 2'd0;
            acc_nxt     = '0;
            if (mode_r == jsu_pkg::MODE_LHEX) begin
              if (cp16 < jsu_pkg::LO_SUR_MIN || cp16 > jsu_pkg::LO_SUR_MAX) begin
                grp = jsu_pkg::end_grp(jsu_pkg::ST_ERR);
              end else begin
                grp = jsu_pkg::utf8_encode(cp_supp);
              end
              clr = 1'b1;
            end else if (cp16 >= jsu_pkg::HI_SUR_MIN && cp16 <= jsu_pkg::HI_SUR_MAX) begin
              high_nxt = cp16[9:0];
              mode_nxt = jsu_pkg::MODE_SBS;
            end else if ((cp16 >= jsu_pkg::LO_SUR_MIN && cp16 <= jsu_pkg::LO_SUR_MAX)
                         || cp16 == 16'h0000) begin
              grp = jsu_pkg::end_grp(jsu_pkg::ST_ERR);
              clr = 1'b1;
            end else begin
              grp      = jsu_pkg::utf8_encode({5'd0, cp16});
              mode_nxt = jsu_pkg::MODE_NORMAL;
            end
          end
        end
        jsu_pkg::MODE_SBS: begin
          if (in_byte != jsu_pkg::CH_BSL) begin
            grp = jsu_pkg::end_grp(jsu_pkg::ST_ERR);
            clr = 1'b1;
          end else begin
            mode_nxt = jsu_pkg::MODE_SU;
          end
        end
        jsu_pkg::MODE_SU: begin
          if (in_byte != jsu_pkg::CH_U) begin
            grp = jsu_pkg::end_grp(jsu_pkg::ST_ERR);
            clr = 1'b1;
          end else begin
            mode_nxt    = jsu_pkg::MODE_LHEX;
            hex_cnt_nxt = 2'd0;
            acc_nxt     = '0;
          end
        end
        default: begin
          mode_nxt = jsu_pkg::MODE_NORMAL;
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            grp = jsu_pkg::end_grp(jsu_pkg::ST_DONE);
            clr = 1'b1;
          end else if (in_byte == jsu_pkg::CH_BSL) begin
            mode_nxt = jsu_pkg::MODE_ESC;
          end else begin
            grp.cnt     = 3'd1;
            grp.status  = jsu_pkg::ST_DATA;
            grp.data[0] = in_byte;
          end
        end
      endcase
    end
    if (clr) begin
      mode_nxt    = jsu_pkg::MODE_NORMAL;
      hex_cnt_nxt = 2'd0;
      acc_nxt     = '0;
      high_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= jsu_pkg::MODE_NORMAL;
      hex_cnt_r <= 2'd0;
      acc_r     <= '0;
      high_r    <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      acc_r     <= acc_nxt;
      high_r    <= high_nxt;
    end
  end

endmodule

### sv/jsu_burst_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_burst_buf
// Two-group result queue: holds the burst being sent plus one waiting group
// and serializes each group into one result transaction per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module jsu_burst_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::grp_t push_grp,
  output logic          can_push,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic [1:0]    out_status,
  output logic          out_last
);

  jsu_pkg::grp_t head_r, head_nxt;
  jsu_pkg::grp_t skid_r, skid_nxt;
  logic          head_v_r, head_v_nxt;
  logic          skid_v_r, skid_v_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          at_last;

  assign at_last    = ({1'b0, idx_r} == (head_r.cnt - 3'd1));
  assign can_push   = !skid_v_r;
  assign out_valid  = head_v_r;
  assign out_byte   = head_r.data[idx_r];
  assign out_status = head_r.status;
  assign out_last   = at_last;

  always_comb begin
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    idx_nxt    = idx_r;
    if (head_v_r && out_ready) begin
      if (at_last) begin
        head_v_nxt = 1'b0;
        idx_nxt    = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (!head_v_nxt && skid_v_nxt) begin
      head_nxt   = skid_r;
      head_v_nxt = 1'b1;
      skid_v_nxt = 1'b0;
    end
    if (push) begin
      if (!head_v_nxt) begin
        head_nxt   = push_grp;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_grp;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
      idx_r    <= 2'd0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### sv/json_string_unescape_utf8_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// Decodes a JSON string body, one raw byte per input transaction, into UTF-8
// result transactions. Plain bytes pass through; the single-character
// escapes and \uXXXX escapes (with surrogate pairs) are expanded; a closing
// quote gives a done result and malformed text gives an error result, after
// which decoding restarts in normal mode. One input byte is accepted per
// cycle while the output queue has room. A byte yields zero to four
// results, sent one per cycle while the output is ready; the output queue
// holds the burst in flight and one more group, so input stalls only when
// both are occupied.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core (
  input  logic       clk,
  input  logic       rst_n,
  jsu_in_if.sink     in_s,
  jsu_out_if.source  out_m
);

  jsu_pkg::grp_t grp;
  logic          can_push;
  logic          in_fire;

  assign in_s.ready = can_push;
  assign in_fire    = in_s.valid && can_push;

  jsu_decoder u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_fire),
    .in_byte (in_s.in_byte),
    .grp     (grp)
  );

  jsu_burst_buf u_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire && (grp.cnt != 3'd0)),
    .push_grp   (grp),
    .can_push   (can_push),
    .out_valid  (out_m.valid),
    .out_ready  (out_m.ready),
    .out_byte   (out_m.out_byte),
    .out_status (out_m.status),
    .out_last   (out_m.last)
  );

endmodule

### sv/jsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] status,
  input logic       last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != jsu_pkg::ST_DATA) |-> last && (out_byte == 8'h00))
    else $error("done or error result not a lone zero byte");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == jsu_pkg::ST_DATA || status == jsu_pkg::ST_DONE
                   || status == jsu_pkg::ST_ERR))
    else $error("undefined status code");

  a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_s.ready),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_byte  (out_m.out_byte),
  .status    (out_m.status),
  .last      (out_m.last)
);
